FILE: design/qtt_pkg.sv
// Types, character codes and token kinds shared by the query text tokenizer.
// No dependencies.
package qtt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_BLOCK
   } mode_type;

   typedef enum logic [3:0] {
      KIND_UNKNOWN = 4'd0,
      KIND_LPAREN  = 4'd1,
      KIND_RPAREN  = 4'd2,
      KIND_SPACE   = 4'd3,
      KIND_STAR    = 4'd4,
      KIND_SEMI    = 4'd5,
      KIND_COMMA   = 4'd6,
      KIND_DOT     = 4'd7,
      KIND_SLASH   = 4'd8,
      KIND_PLUS    = 4'd9,
      KIND_MINUS   = 4'd10,
      KIND_EQUAL   = 4'd11,
      KIND_IDENT   = 4'd12,
      KIND_NUMBER  = 4'd13,
      KIND_STRING  = 4'd14
   } kind_type;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        unterm;
   } token_type;

   // One or two tokens caused by a single input byte
   typedef struct packed {
      logic      pair;
      token_type first;
      token_type second;
   } entry_type;

   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_SPACE:  k = KIND_SPACE;
         CH_STAR:   k = KIND_STAR;
         CH_SEMI:   k = KIND_SEMI;
         CH_COMMA:  k = KIND_COMMA;
         CH_DOT:    k = KIND_DOT;
         CH_SLASH:  k = KIND_SLASH;
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_EQUAL:  k = KIND_EQUAL;
         default:   k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

FILE: design/qtt_scan.sv
// Front end: classifies each byte, tracks the open token and forms finished tokens.
// Depends on qtt_pkg.
module qtt_scan import qtt_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  logic [7:0] char_code,
   input  logic      end_of_text,
   output logic      emit,
   output entry_type entry
);

   localparam int PW = (OFFSET_BITS >= 16) ? 16 : OFFSET_BITS;
   localparam logic [PW-1:0] POS_MAX = '1;

   mode_type mode_ff, mode_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] start_ff, start_in;

   logic is_letter, is_digit, is_opener, bg_emit, run_cont, has_tok, pair;
   logic [7:0] closer;
   logic [PW:0] len_inc, len_exc;
   logic [15:0] pos16, start16;
   kind_type run_kind;
   mode_type bg_mode;
   token_type bg_tok, first_tok;

   function automatic logic [15:0] sat_len(input logic [PW:0] v);
      logic [15:0] r;
      if (v == '0) begin
         r = 16'd1;
      end else if (v[PW]) begin
         r = 16'(POS_MAX);
      end else begin
         r = 16'(v[PW-1:0]);
      end
      return r;
   endfunction

   assign is_letter = (char_code >= CH_LOW_A) && (char_code <= CH_LOW_Z);
   assign is_digit  = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
   assign is_opener = (char_code == CH_QUOTE) || (char_code == CH_LBRACE);
   assign pos16     = 16'(pos_ff);
   assign start16   = 16'(start_ff);
   assign len_inc   = {1'b0, pos_ff} - {1'b0, start_ff} + {{PW{1'b0}}, 1'b1};
   assign len_exc   = {1'b0, pos_ff - start_ff};
   assign run_kind  = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
   assign run_cont  = (mode_ff == MODE_IDENT) ? is_letter : is_digit;
   assign closer    = (mode_ff == MODE_STRING) ? CH_QUOTE : CH_RBRACE;

   // Token that the current byte starts, if it closes at once
   always_comb begin
      bg_emit = !(is_letter || is_digit || is_opener) || end_of_text;
      if (is_letter) begin
         bg_tok.kind = KIND_IDENT;
         bg_mode     = MODE_IDENT;
      end else if (is_digit) begin
         bg_tok.kind = KIND_NUMBER;
         bg_mode     = MODE_NUMBER;
      end else if (is_opener) begin
         bg_tok.kind = KIND_STRING;
         bg_mode     = (char_code == CH_QUOTE) ? MODE_STRING : MODE_BLOCK;
      end else begin
         bg_tok.kind = punct_kind(char_code);
         bg_mode     = MODE_BLOCK;
      end
      bg_tok.start  = pos16;
      bg_tok.length = 16'd1;
      bg_tok.unterm = is_opener;
   end

   always_comb begin
      has_tok          = 1'b0;
      pair             = 1'b0;
      first_tok        = bg_tok;
      mode_in          = mode_ff;
      start_in         = start_ff;
      unique case (mode_ff)
         MODE_IDENT, MODE_NUMBER: begin
            first_tok.kind   = run_kind;
            first_tok.start  = start16;
            first_tok.unterm = 1'b0;
            if (run_cont) begin
               first_tok.length = sat_len(len_inc);
               if (end_of_text) begin
                  has_tok = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end else begin
               // close the run, then treat this byte as a fresh start
               first_tok.length = sat_len(len_exc);
               has_tok          = 1'b1;
               mode_in          = MODE_IDLE;
               if (bg_emit) begin
                  pair = 1'b1;
               end else begin
                  mode_in  = bg_mode;
                  start_in = pos_ff;
               end
            end
         end
         MODE_STRING, MODE_BLOCK: begin
            first_tok.kind   = KIND_STRING;
            first_tok.start  = start16;
            first_tok.length = sat_len(len_inc);
            first_tok.unterm = (char_code != closer);
            if ((char_code == closer) || end_of_text) begin
               has_tok = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (bg_emit) begin
               has_tok = 1'b1;
            end else begin
               mode_in  = bg_mode;
               start_in = pos_ff;
            end
         end
      endcase

      if (end_of_text) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
      end else if (pos_ff == POS_MAX) begin
         pos_in = POS_MAX;
      end else begin
         pos_in = pos_ff + {{(PW-1){1'b0}}, 1'b1};
      end
   end

   assign entry = {pair, first_tok, bg_tok};
   assign emit  = has_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

endmodule

FILE: design/qtt_queue.sv
// Short queue of token entries between the scanner and the result side.
// Depends on qtt_pkg.
module qtt_queue import qtt_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_entry,
   input  logic      pop,
   output entry_type rd_entry,
   output logic      full,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == LAST_SLOT) ? '0 : p + {{(AW-1){1'b0}}, 1'b1};
      return r;
   endfunction

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + {{(CW-1){1'b0}}, 1'b1};
      end else if (do_pop && !do_push) begin
         count_in = count_ff - {{(CW-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/qtt_drain.sv
// Back end: hands out the tokens of the oldest entry one at a time.
// Depends on qtt_pkg.
module qtt_drain import qtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        head_empty,
   input  logic        rsp_pop,
   output logic        head_pop,
   output logic [3:0]  token_kind,
   output logic [15:0] start_offset,
   output logic [15:0] token_length,
   output logic        unterminated,
   output logic        last_of_run
);

   logic sel_ff, sel_in, fire;
   token_type tok;

   assign tok          = sel_ff ? head.second : head.first;
   assign last_of_run  = !head.pair || sel_ff;
   assign token_kind   = tok.kind;
   assign start_offset = tok.start;
   assign token_length = tok.length;
   assign unterminated = tok.unterm;
   assign fire         = rsp_pop && !head_empty;
   // release the entry only once its final token has gone
   assign head_pop     = fire && last_of_run;
   assign sel_in       = fire ? !last_of_run : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

FILE: design/query_text_tokenizer.sv
// Query text tokenizer: byte stream in, tokens (kind, start, length) out.
// Usage:
//   Input side is a queue write port: drive req_char_code / req_end_of_text
//   with req_push; a byte is taken on a clock edge where req_push is high and
//   req_full is low. Mark the final byte of a buffer with req_end_of_text;
//   the next byte then starts a new buffer at offset zero.
//   Result side is a queue read port: while rsp_empty is low the oldest token
//   is on the rsp_ ports; raise rsp_pop to take it.
// Closing: a token is written into the entry queue when the byte that closes it is taken.
//   Identifier and number runs close on the byte after them or on end of text.
// Throughput: one byte per cycle while req_full is low. A byte that ends a run and is itself a
//   one-byte token gives two results, read out one at a time by the result
//   side; the entry queue (QUEUE_DEPTH entries) soaks up such bursts.
// Stalls: when rsp_pop stays low the entry queue fills and req_full rises;
//   bytes that give no result are also held back then.
// Reset (synchronous, active high) empties the queue, closes any open token
//   and sets the byte offset to zero. No clearing pass is needed.
// Depends on qtt_pkg, qtt_scan, qtt_queue and qtt_drain.
module query_text_tokenizer import qtt_pkg::*; #(
   parameter int OFFSET_BITS = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_unterminated,
   output logic        rsp_last_of_run
);

   logic take, emit, head_pop, q_full, q_empty;
   entry_type new_entry, head;

   assign req_full  = q_full;
   assign rsp_empty = q_empty;
   assign take      = req_push && !q_full;

   qtt_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .emit        (emit),
      .entry       (new_entry)
   );

   qtt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take && emit),
      .wr_entry (new_entry),
      .pop      (head_pop),
      .rd_entry (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   qtt_drain u_drain (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_empty   (q_empty),
      .rsp_pop      (rsp_pop),
      .head_pop     (head_pop),
      .token_kind   (rsp_token_kind),
      .start_offset (rsp_start_offset),
      .token_length (rsp_token_length),
      .unterminated (rsp_unterminated),
      .last_of_run  (rsp_last_of_run)
   );

   // Taking the first of a pair must leave its second token on show
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_last_of_run |=> !rsp_empty && rsp_last_of_run)
      else $error("second token of a pair went missing");

   // Only a closed letter or digit run can be followed by a second token
   a_pair_head_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_last_of_run |->
         (rsp_token_kind == KIND_IDENT) || (rsp_token_kind == KIND_NUMBER))
      else $error("pair opened by a token that is not a run");

   a_unterm_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_unterminated |-> rsp_token_kind == KIND_STRING)
      else $error("unterminated flag on a token that is not a string");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

endmodule

FILE: tb/tb_tokenizer_pkg.sv
// Token scoreboard for the query text tokenizer testbench: predicts the tokens
// that each accepted byte produces and checks the tokens that come out.
// Depends on qtt_pkg for kinds, scan modes and character codes.
package tb_tokenizer_pkg;
   import qtt_pkg::*;

   localparam int unsigned OFFSET_LIMIT = 65535;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        unterm;
      logic        last;
   } token_rec_type;

   class token_scoreboard;
      mode_type      mode;
      logic [15:0]   pos;
      logic [15:0]   open_start;
      token_rec_type waiting[$];
      int            errors;

      function new();
         mode       = MODE_IDLE;
         pos        = '0;
         open_start = '0;
         errors     = 0;
      endfunction

      function bit is_letter(logic [7:0] c);
         return c >= CH_LOW_A && c <= CH_LOW_Z;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
      endfunction

      function kind_type single_kind(logic [7:0] c);
         case (c)
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_SPACE:  return KIND_SPACE;
            CH_STAR:   return KIND_STAR;
            CH_SEMI:   return KIND_SEMI;
            CH_COMMA:  return KIND_COMMA;
            CH_DOT:    return KIND_DOT;
            CH_SLASH:  return KIND_SLASH;
            CH_PLUS:   return KIND_PLUS;
            CH_MINUS:  return KIND_MINUS;
            CH_EQUAL:  return KIND_EQUAL;
            default:   return KIND_UNKNOWN;
         endcase
      endfunction

      // Clamp the length to 1 .. offset limit before queueing
      function void add_token(kind_type k, logic [15:0] st, int unsigned len, logic u);
         token_rec_type t;
         if (len < 1)
            len = 1;
         else if (len > OFFSET_LIMIT)
            len = OFFSET_LIMIT;
         t.kind   = k;
         t.start  = st;
         t.length = len[15:0];
         t.unterm = u;
         t.last   = 1'b0;
         waiting.push_back(t);
      endfunction

      function void open_token(logic [7:0] c, logic eot);
         if (is_letter(c) || is_digit(c)) begin
            if (eot)
               add_token(is_letter(c) ? KIND_IDENT : KIND_NUMBER, pos, 1, 1'b0);
            else begin
               mode       = is_letter(c) ? MODE_IDENT : MODE_NUMBER;
               open_start = pos;
            end
         end else if (c == CH_QUOTE || c == CH_LBRACE) begin
            if (eot)
               add_token(KIND_STRING, pos, 1, 1'b1);
            else begin
               mode       = (c == CH_QUOTE) ? MODE_STRING : MODE_BLOCK;
               open_start = pos;
            end
         end else begin
            add_token(single_kind(c), pos, 1, 1'b0);
         end
      endfunction

      function void note_byte(logic [7:0] c, logic eot);
         logic [15:0] s;
         int unsigned p;
         int unsigned q;
         int          prior_size;
         bit          cont;
         kind_type    run_kind;
         logic [7:0]  closer;
         prior_size = waiting.size();
         s = open_start;
         if (s > pos)
            s = pos;
         p = pos;
         q = s;
         case (mode)
            MODE_IDENT, MODE_NUMBER: begin
               cont     = (mode == MODE_IDENT) ? is_letter(c) : is_digit(c);
               run_kind = (mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
               if (cont) begin
                  if (eot) begin
                     add_token(run_kind, s, p - q + 1, 1'b0);
                     mode = MODE_IDLE;
                  end
               end else begin
                  // the byte that ends the run starts a token of its own
                  add_token(run_kind, s, p - q, 1'b0);
                  mode = MODE_IDLE;
                  open_token(c, eot);
               end
            end
            MODE_STRING, MODE_BLOCK: begin
               closer = (mode == MODE_STRING) ? CH_QUOTE : CH_RBRACE;
               if (c == closer) begin
                  add_token(KIND_STRING, s, p - q + 1, 1'b0);
                  mode = MODE_IDLE;
               end else if (eot) begin
                  add_token(KIND_STRING, s, p - q + 1, 1'b1);
                  mode = MODE_IDLE;
               end
            end
            default: begin
               mode = MODE_IDLE;
               open_token(c, eot);
            end
         endcase
         if (waiting.size() > prior_size)
            waiting[waiting.size() - 1].last = 1'b1;
         if (eot) begin
            mode       = MODE_IDLE;
            pos        = '0;
            open_start = '0;
         end else if (pos < OFFSET_LIMIT) begin
            pos = pos + 16'd1;
         end
      endfunction

      function void check_token(logic [3:0] kind, logic [15:0] start, logic [15:0] length,
                                logic unterm, logic last, longint unsigned stamp);
         token_rec_type want;
         if (waiting.size() == 0) begin
            errors++;
            $display("%0d ns: token with none expected: kind %0d start %0d len %0d",
                     stamp, kind, start, length);
            return;
         end
         want = waiting.pop_front();
         if (4'(want.kind) !== kind || want.start !== start || want.length !== length ||
             want.unterm !== unterm || want.last !== last) begin
            errors++;
            $display({"%0d ns: token mismatch: expected kind %0d start %0d len %0d ",
                      "unterm %0b last %0b, got kind %0d start %0d len %0d unterm %0b ",
                      "last %0b"},
                     stamp, want.kind, want.start, want.length, want.unterm, want.last,
                     kind, start, length, unterm, last);
         end
      endfunction

      function int pending();
         return waiting.size();
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// Top of the query text tokenizer testbench: clock, reset, byte sender,
// token receiver and watchdog around query_text_tokenizer.
// Depends on qtt_pkg and tb_tokenizer_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qtt_pkg::*;
   import tb_tokenizer_pkg::*;

   localparam int RANDOM_BYTES = 1300;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int IDLE_PERCENT = 27;

   localparam logic [7:0] SINGLE_CODES [11] = '{CH_LPAREN, CH_RPAREN, CH_SPACE, CH_STAR,
      CH_SEMI, CH_COMMA, CH_DOT, CH_SLASH, CH_PLUS, CH_MINUS, CH_EQUAL};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_char_code = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_unterminated;
   logic        rsp_last_of_run;

   token_scoreboard tokens = new();
   logic [7:0]      text_buf[$];
   bit              calm = 1'b0;
   int              hold_requests = 0;
   int              quiet = 0;

   query_text_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_unterminated (rsp_unterminated),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #2ns clock = ~clock;

   // Offer one byte, idling at random first, and hold it until it is taken
   task automatic send_byte(input logic [7:0] c, input logic last_byte);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_char_code   <= c;
      req_end_of_text <= last_byte;
      do
         @(posedge clock);
      while (req_full);
      tokens.note_byte(c, last_byte);
   endtask

   task automatic send_text(input string s, input bit close_buf);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], close_buf && i == s.len() - 1);
   endtask

   function automatic logic [7:0] byte_other_than(logic [7:0] closer);
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == closer);
      return b;
   endfunction

   // Append one piece of query text or a random byte; strings and blocks may stay open
   task automatic append_fragment(input bit leave_open);
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 28) begin
         n = $urandom_range(1, 10);
         repeat (n) text_buf.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
      end else if (pick < 46) begin
         n = $urandom_range(1, 8);
         repeat (n) text_buf.push_back(8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)));
      end else if (pick < 61) begin
         n = $urandom_range(0, 8);
         text_buf.push_back(CH_QUOTE);
         repeat (n) text_buf.push_back(byte_other_than(CH_QUOTE));
         if (!leave_open)
            text_buf.push_back(CH_QUOTE);
      end else if (pick < 71) begin
         n = $urandom_range(0, 8);
         text_buf.push_back(CH_LBRACE);
         repeat (n) text_buf.push_back(byte_other_than(CH_RBRACE));
         if (!leave_open)
            text_buf.push_back(CH_RBRACE);
      end else if (pick < 88) begin
         text_buf.push_back(SINGLE_CODES[$urandom_range(10)]);
      end else begin
         text_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin : stimulus
      int  buf_count;
      int  sent;
      int  frags;
      bit  close_buf;
      buf_count = 0;
      sent      = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every kind, a run ended by a one-byte token, odd bytes, closes by end of text
      send_text("az(09) *;,./+-=", 1'b0);
      send_text("\"x\"{a}", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("A}7", 1'b1);
      send_text("\"ab", 1'b1);
      send_text("{", 1'b1);
      send_text("xy", 1'b1);
      send_text("(ab9\"k\"{x", 1'b1);

      while (sent < RANDOM_BYTES) begin
         buf_count++;
         calm <= (buf_count >= 30 && buf_count < 42);
         if (buf_count == 12 || buf_count == 45)
            hold_requests <= hold_requests + 1;
         if (buf_count == 25) begin
            // let the result side drain completely
            req_push <= 1'b0;
            while (tokens.pending() != 0)
               @(posedge clock);
         end
         text_buf.delete();
         frags = $urandom_range(1, 10);
         for (int k = 0; k < frags; k++)
            append_fragment(k == frags - 1 && $urandom_range(99) < 25);
         close_buf = $urandom_range(99) < 85;
         foreach (text_buf[i])
            send_byte(text_buf[i], close_buf && i == text_buf.size() - 1);
         sent += text_buf.size();
      end
      req_push <= 1'b0;

      while (tokens.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tokens.errors == 0 && tokens.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            tokens.check_token(rsp_token_kind, rsp_start_offset, rsp_token_length,
                               rsp_unterminated, rsp_last_of_run, $time);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= calm || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   // End the run when neither side has moved an item for too long
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

FILE: filelist.f
design/qtt_pkg.sv
design/qtt_scan.sv
design/qtt_queue.sv
design/qtt_drain.sv
design/query_text_tokenizer.sv
tb/tb_tokenizer_pkg.sv
tb/tb_top.sv
